/* design/ebalu_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the eight-bit alu with flags
// no dependencies; used by ebalu_core and eight_bit_alu_with_flags
package ebalu_pkg;

  // operation codes
  typedef enum logic [4:0] {
    ACT_ADD  = 5'd0,
    ACT_ADC  = 5'd1,
    ACT_SUB  = 5'd2,
    ACT_SBC  = 5'd3,
    ACT_AND  = 5'd4,
    ACT_XOR  = 5'd5,
    ACT_OR   = 5'd6,
    ACT_CP   = 5'd7,
    ACT_INC  = 5'd8,
    ACT_DEC  = 5'd9,
    ACT_DAA  = 5'd10,
    ACT_CPL  = 5'd11,
    ACT_RLC  = 5'd12,
    ACT_RRC  = 5'd13,
    ACT_RL   = 5'd14,
    ACT_RR   = 5'd15,
    ACT_RLCA = 5'd16,
    ACT_RRCA = 5'd17,
    ACT_RLA  = 5'd18,
    ACT_RRA  = 5'd19,
    ACT_SLA  = 5'd20,
    ACT_SRA  = 5'd21,
    ACT_SRL  = 5'd22,
    ACT_SWAP = 5'd23,
    ACT_BIT  = 5'd24,
    ACT_SET  = 5'd25,
    ACT_RES  = 5'd26,
    ACT_CCF  = 5'd27,
    ACT_SCF  = 5'd28
  } action_e;

  // flag bit positions in the flag nibble
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // daa correction constants
  localparam logic [7:0] DAA_HI_FIX  = 8'h60;
  localparam logic [7:0] DAA_LO_FIX  = 8'h06;
  localparam logic [7:0] DAA_BCD_MAX = 8'h99;
  localparam logic [3:0] DAA_NIB_MAX = 4'h9;
  localparam logic [7:0] DAA_SUB_CH  = 8'h9A;
  localparam logic [7:0] DAA_SUB_C   = 8'hA0;
  localparam logic [7:0] DAA_SUB_H   = 8'hFA;

  // request: one alu operation
  typedef struct packed {
    logic [4:0] action;
    logic [7:0] accumulator;
    logic [7:0] operand;
    logic [3:0] flags_in;
    logic [2:0] bit_index;
  } req_t;

  // response: result byte, new flags, write enable
  typedef struct packed {
    logic [7:0] result;
    logic [3:0] flags_out;
    logic       writes_result;
  } rsp_t;

endpackage

/* design/ebalu_core.sv */
`timescale 1ns / 1ps
// combinational datapath of the eight-bit alu: one request in, one response out
// depends on ebalu_pkg for the request/response types and operation codes
module ebalu_core (
  input  ebalu_pkg::req_t req_i,
  output ebalu_pkg::rsp_t rsp_o
);

  logic [7:0] a;
  logic [7:0] b;
  logic [3:0] fl;
  logic       cin;
  logic       cin_arith;
  logic [7:0] mask;
  logic [8:0] sum9;
  logic [4:0] sum_lo;
  logic [8:0] dif9;
  logic [4:0] dif_lo;
  logic [7:0] daa_r;
  logic       daa_c;
  logic [7:0] res;
  logic [3:0] flg;
  logic       wr;
  logic       zero;

  assign a    = req_i.accumulator;
  assign b    = req_i.operand;
  assign fl   = req_i.flags_in;
  assign cin  = fl[ebalu_pkg::FLAG_C];
  assign mask = 8'd1 << req_i.bit_index;

  // carry-in only for adc and sbc
  assign cin_arith = ((req_i.action == ebalu_pkg::ACT_ADC) ||
                      (req_i.action == ebalu_pkg::ACT_SBC)) ? cin : 1'b0;

  // shared adder and subtractor with half-carry nibble paths
  assign sum9   = {1'b0, a} + {1'b0, b} + {8'd0, cin_arith};
  assign sum_lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin_arith};
  assign dif9   = {1'b0, a} - {1'b0, b} - {8'd0, cin_arith};
  assign dif_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin_arith};

  // decimal adjust
  always_comb begin
    daa_r = a;
    daa_c = cin;
    if (!fl[ebalu_pkg::FLAG_N]) begin
      if (cin || (a > ebalu_pkg::DAA_BCD_MAX)) begin
        daa_r = daa_r + ebalu_pkg::DAA_HI_FIX;
        daa_c = 1'b1;
      end
      if (fl[ebalu_pkg::FLAG_H] || (a[3:0] > ebalu_pkg::DAA_NIB_MAX)) begin
        daa_r = daa_r + ebalu_pkg::DAA_LO_FIX;
      end
    end else begin
      if (cin && fl[ebalu_pkg::FLAG_H]) begin
        daa_r = a + ebalu_pkg::DAA_SUB_CH;
      end else if (cin) begin
        daa_r = a + ebalu_pkg::DAA_SUB_C;
      end else if (fl[ebalu_pkg::FLAG_H]) begin
        daa_r = a + ebalu_pkg::DAA_SUB_H;
      end
    end
  end

  // operation select; z is filled in from the result where the op sets it
  always_comb begin
    res = 8'd0;
    flg = fl;
    wr  = 1'b1;
    case (req_i.action)
      ebalu_pkg::ACT_ADD, ebalu_pkg::ACT_ADC: begin
        res = sum9[7:0];
        flg = {1'b0, 1'b0, sum_lo[4], sum9[8]};
      end
      ebalu_pkg::ACT_SUB, ebalu_pkg::ACT_SBC: begin
        res = dif9[7:0];
        flg = {1'b0, 1'b1, dif_lo[4], dif9[8]};
      end
      ebalu_pkg::ACT_CP: begin
        res = a;
        flg = {(dif9[7:0] == 8'd0), 1'b1, dif_lo[4], dif9[8]};
        wr  = 1'b0;
      end
      ebalu_pkg::ACT_AND: begin
        res = a & b;
        flg = 4'b0010;
      end
      ebalu_pkg::ACT_XOR: begin
        res = a ^ b;
        flg = 4'b0000;
      end
      ebalu_pkg::ACT_OR: begin
        res = a | b;
        flg = 4'b0000;
      end
      ebalu_pkg::ACT_INC: begin
        res = b + 8'd1;
        flg = {1'b0, 1'b0, (b[3:0] == 4'hF), cin};
      end
      ebalu_pkg::ACT_DEC: begin
        res = b - 8'd1;
        flg = {1'b0, 1'b1, (b[3:0] == 4'h0), cin};
      end
      ebalu_pkg::ACT_DAA: begin
        res = daa_r;
        flg = {1'b0, fl[ebalu_pkg::FLAG_N], 1'b0, daa_c};
      end
      ebalu_pkg::ACT_CPL: begin
        res = ~a;
        flg = {fl[ebalu_pkg::FLAG_Z], 1'b1, 1'b1, cin};
      end
      ebalu_pkg::ACT_RLC: begin
        res = {b[6:0], b[7]};
        flg = {3'b000, b[7]};
      end
      ebalu_pkg::ACT_RRC: begin
        res = {b[0], b[7:1]};
        flg = {3'b000, b[0]};
      end
      ebalu_pkg::ACT_RL: begin
        res = {b[6:0], cin};
        flg = {3'b000, b[7]};
      end
      ebalu_pkg::ACT_RR: begin
        res = {cin, b[7:1]};
        flg = {3'b000, b[0]};
      end
      ebalu_pkg::ACT_RLCA: begin
        res = {a[6:0], a[7]};
        flg = {3'b000, a[7]};
      end
      ebalu_pkg::ACT_RRCA: begin
        res = {a[0], a[7:1]};
        flg = {3'b000, a[0]};
      end
      ebalu_pkg::ACT_RLA: begin
        res = {a[6:0], cin};
        flg = {3'b000, a[7]};
      end
      ebalu_pkg::ACT_RRA: begin
        res = {cin, a[7:1]};
        flg = {3'b000, a[0]};
      end
      ebalu_pkg::ACT_SLA: begin
        res = {b[6:0], 1'b0};
        flg = {3'b000, b[7]};
      end
      ebalu_pkg::ACT_SRA: begin
        res = {b[7], b[7:1]};
        flg = {3'b000, b[0]};
      end
      ebalu_pkg::ACT_SRL: begin
        res = {1'b0, b[7:1]};
        flg = {3'b000, b[0]};
      end
      ebalu_pkg::ACT_SWAP: begin
        res = {b[3:0], b[7:4]};
        flg = 4'b0000;
      end
      ebalu_pkg::ACT_BIT: begin
        res = b;
        flg = {((b & mask) == 8'd0), 1'b0, 1'b1, cin};
        wr  = 1'b0;
      end
      ebalu_pkg::ACT_SET: begin
        res = b | mask;
      end
      ebalu_pkg::ACT_RES: begin
        res = b & ~mask;
      end
      ebalu_pkg::ACT_CCF: begin
        res = a;
        flg = {fl[ebalu_pkg::FLAG_Z], 2'b00, ~cin};
        wr  = 1'b0;
      end
      ebalu_pkg::ACT_SCF: begin
        res = a;
        flg = {fl[ebalu_pkg::FLAG_Z], 2'b00, 1'b1};
        wr  = 1'b0;
      end
      default: begin
        res = 8'd0;
        flg = fl;
        wr  = 1'b0;
      end
    endcase
  end

  assign zero = (res == 8'd0);

  // ops whose z flag comes from the result byte
  always_comb begin
    rsp_o.result        = res;
    rsp_o.flags_out     = flg;
    rsp_o.writes_result = wr;
    case (req_i.action)
      ebalu_pkg::ACT_ADD, ebalu_pkg::ACT_ADC, ebalu_pkg::ACT_SUB, ebalu_pkg::ACT_SBC,
      ebalu_pkg::ACT_AND, ebalu_pkg::ACT_XOR, ebalu_pkg::ACT_OR, ebalu_pkg::ACT_INC,
      ebalu_pkg::ACT_DEC, ebalu_pkg::ACT_DAA, ebalu_pkg::ACT_RLC, ebalu_pkg::ACT_RRC,
      ebalu_pkg::ACT_RL, ebalu_pkg::ACT_RR, ebalu_pkg::ACT_SLA, ebalu_pkg::ACT_SRA,
      ebalu_pkg::ACT_SRL, ebalu_pkg::ACT_SWAP: begin
        rsp_o.flags_out[ebalu_pkg::FLAG_Z] = zero;
      end
      default: begin
        rsp_o.flags_out = flg;
      end
    endcase
  end

endmodule

/* design/eight_bit_alu_with_flags.sv */
`timescale 1ns / 1ps
// eight-bit alu with z/n/h/c flags: start reaches done_o through the request register,
// then the result register, around one combinational pass
// throughput one request per cycle; busy stays low and done_o is a one-cycle strobe
// the receiver cannot stall, so results are never held back
// reset (rst_ni low, asynchronous) clears the valid bits; payload registers are not reset
// depends on ebalu_pkg and ebalu_core
module eight_bit_alu_with_flags (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  ebalu_pkg::req_t req_i,
  output logic            done_o,
  output ebalu_pkg::rsp_t rsp_o
);

  logic            valid_d, valid_q;
  ebalu_pkg::req_t req_d, req_q;
  logic            done_d, done_q;
  ebalu_pkg::rsp_t rsp_d, rsp_q;

  // never blocks: a request is taken every cycle
  assign busy = 1'b0;

  // request register
  assign valid_d = start && !busy;
  assign req_d   = req_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_d) begin
      req_q <= req_d;
    end
  end

  // single combinational pass
  ebalu_core u_core (
    .req_i (req_q),
    .rsp_o (rsp_d)
  );

  // result register
  assign done_d = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // every request gives exactly one strobe, in the cycle after it is registered
  a_valid_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> done_q) else $error("request lost in result stage");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q |=> !done_q) else $error("strobe without request");

  // compare keeps the accumulator and does not write
  a_cp_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (req_q.action == ebalu_pkg::ACT_CP)) |=>
    ((rsp_q.result == $past(req_q.accumulator)) && !rsp_q.writes_result))
    else $error("cp altered result or write enable");

  // set keeps all flags
  a_set_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && (req_q.action == ebalu_pkg::ACT_SET)) |=>
    (rsp_q.flags_out == $past(req_q.flags_in)))
    else $error("set changed flags");

endmodule
